@@ hdl/gact_pkg.sv @@
package gact_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int TABLE_SEGMENTS = 256;
  localparam int SEG_LOG        = $clog2(TABLE_SEGMENTS);
  localparam int IQ             = 30;

  // datapath widths
  localparam int MW    = FRAC_BITS + 3;   // |x| < 8
  localparam int AW    = FRAC_BITS + 5;   // table argument, inner sum
  localparam int LW    = FRAC_BITS + 1;   // table entry, up to 1.0
  localparam int RW    = FRAC_BITS + 2;   // position inside a segment
  localparam int M2W   = FRAC_BITS + 6;   // x^2 < 64
  localparam int M3W   = FRAC_BITS + 9;   // x^3 < 512
  localparam int KW    = 30;
  localparam int KCW   = 26;
  localparam int MUL2W = (MW + KW > 2 * MW) ? MW + KW : 2 * MW;
  localparam int CUBW  = M2W + MW;
  localparam int CW    = M3W + KCW;
  localparam int SW    = AW + KW;
  localparam int DW    = LW + RW;
  localparam int GW    = FRAC_BITS + 2;
  localparam int PW    = MW + GW;
  localparam int QF    = 2 * FRAC_BITS + 1;
  localparam int BW    = $clog2(PW);
  localparam int NS    = 12;              // pipeline stages

  localparam logic [KW-1:0]  K_INV_SQRT2      = 30'd759250125;
  localparam logic [KW-1:0]  K_SQRT_2_OVER_PI = 30'd856722024;
  localparam logic [KCW-1:0] K_CUBIC          = 26'd48012366;
  localparam logic [63:0]    K_TWO_SQRT_PI    = 64'd1211587905;
  localparam logic [63:0]    IONE             = 64'd1 << IQ;
  localparam logic [63:0]    SEGS             = 64'(TABLE_SEGMENTS);

  localparam logic [15:0] FP16_INF = 16'h7C00;

  typedef logic [LW-1:0] lut_t [TABLE_SEGMENTS+1];

  typedef struct packed {
    logic          last;
    logic          neg;
    logic          mode;
    logic          spec;
    logic [15:0]   sy;
    logic [MW-1:0] m;
  } ctl_t;

  typedef struct packed {
    logic          sat;
    logic [LW-1:0] lo;
    logic [LW-1:0] hi;
    logic [RW-1:0] r;
  } lk_t;

  // round to nearest even, dropping s fraction bits
  function automatic logic [63:0] rne64(input logic [63:0] v, input int s);
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    if (s <= 0) return v;
    q    = v >> s;
    rem  = v & ((64'd1 << s) - 64'd1);
    half = 64'd1 << (s - 1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    return q;
  endfunction

  // e^((f1/SEGS)*(f2/SEGS)) with IQ fraction bits
  function automatic logic [63:0] exp_rat(input logic [63:0] f1, input logic [63:0] f2);
    logic [63:0] u;
    logic [63:0] s;
    logic        done;
    u    = IONE;
    s    = IONE;
    done = 1'b0;
    for (int n = 1; n < 256 && !done; n++) begin
      u = u * f1 / SEGS;
      u = u / 64'(n);
      u = u * f2 / SEGS;
      if (u == 64'd0) done = 1'b1;
      else s = s + u;
    end
    return s;
  endfunction

  // floor(a * 2^IQ / b), a < 2b, by restoring long division
  function automatic logic [63:0] divfrac(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [63:0] rem;
    q   = (a >= b) ? 64'd1 : 64'd0;
    rem = (a >= b) ? a - b : a;
    for (int i = 0; i < IQ; i++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= b) begin
        rem  = rem - b;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [LW-1:0] to_table(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] one;
    r   = rne64(v, IQ - FRAC_BITS);
    one = 64'd1 << FRAC_BITS;
    return LW'((r > one) ? one : r);
  endfunction

  // knots at 4k/SEGS: erf when sel is 0, tanh when sel is 1
  function automatic lut_t build_lut(input logic sel);
    lut_t        tab;
    logic [63:0] t;
    logic [63:0] sum;
    logic [63:0] e;
    logic [63:0] kk;
    logic        done;
    for (int k = 0; k <= TABLE_SEGMENTS; k++) begin
      kk = 64'(k);
      if (!sel) begin
        t    = ((64'd4 * kk) << IQ) / SEGS;
        sum  = t;
        done = 1'b0;
        for (int n = 1; n < 256 && !done; n++) begin
          t = t * (64'd4 * kk) / SEGS;
          t = t / 64'(2 * n + 1);
          t = t * (64'd8 * kk) / SEGS;
          if (t == 64'd0) done = 1'b1;
          else sum = sum + t;
        end
        e      = exp_rat(64'd4 * kk, 64'd4 * kk);
        tab[k] = to_table(rne64(divfrac(sum, e) * K_TWO_SQRT_PI, IQ));
      end else begin
        e      = exp_rat(64'd8 * kk, SEGS);
        tab[k] = to_table(divfrac(e - IONE, e + IONE));
      end
    end
    return tab;
  endfunction

  localparam lut_t ERF_LUT  = build_lut(1'b0);
  localparam lut_t TANH_LUT = build_lut(1'b1);

endpackage

@@ hdl/gact_in_if.sv @@
interface gact_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] x_bits;
  logic        last_in;
  modport source (output valid, output x_bits, output last_in, input ready);
  modport sink   (input valid, input x_bits, input last_in, output ready);
endinterface

@@ hdl/gact_out_if.sv @@
interface gact_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] y_bits;
  logic        last_out;
  modport source (output valid, output y_bits, output last_out, input ready);
  modport sink   (input valid, input y_bits, input last_out, output ready);
endinterface

@@ hdl/gact_cfg_if.sv @@
interface gact_cfg_if;
  logic valid;
  logic ready;
  logic mode;
  modport source (output valid, output mode, input ready);
  modport sink   (input valid, input mode, output ready);
endinterface

@@ hdl/gact_lookup.sv @@
module gact_lookup import gact_pkg::*; (
  input  logic [AW-1:0] arg_i,
  input  logic          mode_i,
  output lk_t           lk_o
);

  logic [SEG_LOG:0] idx;

  always_comb begin
    idx       = {1'b0, arg_i[FRAC_BITS+1 -: SEG_LOG]};
    lk_o.sat  = |arg_i[AW-1:FRAC_BITS+2];
    lk_o.lo   = mode_i ? TANH_LUT[idx] : ERF_LUT[idx];
    lk_o.hi   = mode_i ? TANH_LUT[idx + 1'b1] : ERF_LUT[idx + 1'b1];
    lk_o.r    = {arg_i[FRAC_BITS+1-SEG_LOG:0], {SEG_LOG{1'b0}}};
  end

endmodule

@@ hdl/gelu_activation_fp16_top.sv @@
// GELU on FP16, one item per cycle while the receiver keeps out_if.ready high.
//
// in_if   : x_bits (FP16) and last_in; taken when valid and ready are high.
// out_if  : y_bits (FP16) and last_out, in the order the items came in.
// cfg_if  : one bit, mode. 0 = erf form, 1 = tanh form. Always ready;
//           write it only while the pipeline is empty.
//
// Each accepted item passes through every stage register in turn before
// out_if.valid rises. Throughput is one item per cycle while the receiver
// does not stall, set by the 12-stage pipeline (each stage holds at most one
// multiplier or one table read plus an add).
// Stages: input decode, x*k or x^2, x^3, cubic term, inner*k, argument
// round, table read, slope*offset, 1+-f, x*g, leading-one search, FP16 pack.
// NaN and |x| >= 8 ride along as a bypass value and skip the arithmetic.
//
// Each stage moves when it is empty or the stage after it moves, so bubbles
// collapse while the receiver stalls; in_if.ready drops only once every
// stage is full. Reset clears all valid bits and sets mode to 0.
module gelu_activation_fp16_top import gact_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  gact_in_if.sink    in_if,
  gact_out_if.source out_if,
  gact_cfg_if.sink   cfg_if
);

  logic          mode_q;
  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  // stage control words
  ctl_t c1_q, c2_q, c3_q, c4_q, c5_q, c6_q, c7_q, c8_q, c9_q, c10_q, c11_q;
  ctl_t c1_d;

  logic [MUL2W-1:0] mul2_q, mul2_d;
  logic [AW-1:0]    arg3_q, arg4_q, arg5_q, arg6_q, arg3_d, arg6_d;
  logic [CUBW-1:0]  cube3_q, cube3_d;
  logic [CW-1:0]    cub4_q, cub4_d;
  logic [SW-1:0]    prod5_q, prod5_d;
  lk_t              lk7_q, lk7_d;
  logic             sat8_q, dneg8_q, dneg8_d;
  logic [LW-1:0]    lo8_q, dabs8;
  logic [DW-1:0]    dp8_q, dp8_d;
  logic [GW-1:0]    g9_q, g9_d;
  logic [PW-1:0]    p10_q, p10_d, p11_q;
  logic [BW-1:0]    b11_q, b11_d;
  logic [15:0]      y_q, y_d;
  logic             last_q;

  // config
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_if.valid) begin
      mode_q <= cfg_if.mode;
    end
  end

  // stall chain
  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_if.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_if.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_if.valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage 1: decode, fixed-point magnitude
  always_comb begin
    logic [4:0]  e;
    logic [9:0]  fr;
    logic        nan;
    logic [10:0] mant;
    int          sh;
    e        = in_if.x_bits[14:10];
    fr       = in_if.x_bits[9:0];
    nan      = (e == 5'd31) && (fr != 10'd0);
    mant     = {e != 5'd0, fr};
    sh       = ((e == 5'd0) ? 1 : int'(e)) + FRAC_BITS - 25;
    c1_d.last = in_if.last_in;
    c1_d.neg  = in_if.x_bits[15];
    c1_d.mode = mode_q;
    c1_d.spec = nan || (e >= 5'd18);
    c1_d.sy   = (nan || !in_if.x_bits[15]) ? in_if.x_bits : 16'h0000;
    if (sh >= 0) c1_d.m = MW'(64'(mant) << sh);
    else         c1_d.m = MW'(rne64(64'(mant), -sh));
  end

  // stage 2: x*k (erf) or x^2 (tanh)
  always_comb begin
    logic [MUL2W-1:0] op_b;
    op_b   = c1_q.mode ? MUL2W'(c1_q.m) : MUL2W'(K_INV_SQRT2);
    mul2_d = MUL2W'(c1_q.m) * op_b;
  end

  // stage 3: erf argument, or x^3
  always_comb begin
    logic [M2W-1:0] m2;
    m2      = M2W'(rne64(64'(mul2_q), FRAC_BITS));
    arg3_d  = AW'(rne64(64'(mul2_q), IQ));
    cube3_d = CUBW'(m2) * CUBW'(c2_q.m);
  end

  // stage 4: cubic coefficient
  always_comb begin
    logic [M3W-1:0] m3;
    m3     = M3W'(rne64(64'(cube3_q), FRAC_BITS));
    cub4_d = CW'(m3) * CW'(K_CUBIC);
  end

  // stage 5: (x + c*x^3) * sqrt(2/pi)
  always_comb begin
    logic [AW-1:0] inner;
    inner   = AW'(c4_q.m) + AW'(rne64(64'(cub4_q), IQ));
    prod5_d = SW'(inner) * SW'(K_SQRT_2_OVER_PI);
  end

  // stage 6: table argument
  assign arg6_d = c5_q.mode ? AW'(rne64(64'(prod5_q), IQ)) : arg5_q;

  // stage 7: table read
  gact_lookup u_lookup (
    .arg_i  (arg6_q),
    .mode_i (c6_q.mode),
    .lk_o   (lk7_d)
  );

  // stage 8: slope times offset
  always_comb begin
    dneg8_d = lk7_q.hi < lk7_q.lo;
    dabs8   = dneg8_d ? lk7_q.lo - lk7_q.hi : lk7_q.hi - lk7_q.lo;
    dp8_d   = DW'(dabs8) * DW'(lk7_q.r);
  end

  // stage 9: f, then g = 1 +- f
  always_comb begin
    logic [LW-1:0] f;
    logic [LW-1:0] step;
    logic [GW-1:0] one;
    step = LW'(rne64(64'(dp8_q), RW));
    one  = GW'(1) << FRAC_BITS;
    if (sat8_q)       f = LW'(1) << FRAC_BITS;
    else if (dneg8_q) f = lo8_q - step;
    else              f = lo8_q + step;
    g9_d = c8_q.neg ? one - GW'(f) : one + GW'(f);
  end

  // stage 10: x*g
  assign p10_d = PW'(c9_q.m) * PW'(g9_q);

  // stage 11: leading one
  always_comb begin
    b11_d = '0;
    for (int i = 0; i < PW; i++) begin
      if (p10_q[i]) b11_d = BW'(i);
    end
  end

  // stage 12: round to FP16
  always_comb begin
    logic [PW-1:0] pn;
    logic [10:0]   mant;
    logic          up;
    logic [11:0]   mr;
    logic [63:0]   sub;
    int            ef;
    logic [15:0]   bits;
    pn   = p11_q << (PW - 1 - int'(b11_q));
    mant = pn[PW-1 -: 11];
    up   = pn[PW-12] && ((|pn[PW-13:0]) || mant[0]);
    mr   = {1'b0, mant} + 12'(up);
    ef   = int'(b11_q) + 15 - QF + (mr[11] ? 1 : 0);
    sub  = rne64(64'(p11_q), QF - 24);
    if (p11_q == '0) begin
      bits = 16'h0000;
    end else if (int'(b11_q) >= QF - 14) begin
      if (ef >= 31) bits = FP16_INF;
      else          bits = {1'b0, 5'(ef), mr[11] ? mr[10:1] : mr[9:0]};
    end else begin
      bits = {1'b0, sub[14:0]};
    end
    if (c11_q.spec)         y_d = c11_q.sy;
    else if (bits == 16'h0) y_d = 16'h0000;
    else                    y_d = {c11_q.neg, bits[14:0]};
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en[0])  c1_q <= c1_d;
    if (en[1])  begin c2_q <= c1_q;  mul2_q <= mul2_d; end
    if (en[2])  begin c3_q <= c2_q;  arg3_q <= arg3_d; cube3_q <= cube3_d; end
    if (en[3])  begin c4_q <= c3_q;  arg4_q <= arg3_q; cub4_q <= cub4_d; end
    if (en[4])  begin c5_q <= c4_q;  arg5_q <= arg4_q; prod5_q <= prod5_d; end
    if (en[5])  begin c6_q <= c5_q;  arg6_q <= arg6_d; end
    if (en[6])  begin c7_q <= c6_q;  lk7_q <= lk7_d; end
    if (en[7])  begin
      c8_q <= c7_q; sat8_q <= lk7_q.sat; lo8_q <= lk7_q.lo;
      dneg8_q <= dneg8_d; dp8_q <= dp8_d;
    end
    if (en[8])  begin c9_q <= c8_q;  g9_q <= g9_d; end
    if (en[9])  begin c10_q <= c9_q; p10_q <= p10_d; end
    if (en[10]) begin c11_q <= c10_q; p11_q <= p10_q; b11_q <= b11_d; end
    if (en[11]) begin y_q <= y_d; last_q <= c11_q.last; end
  end

  assign out_if.valid    = v_q[NS-1];
  assign out_if.y_bits   = y_q;
  assign out_if.last_out = last_q;

endmodule

@@ hdl/gact_checker.sv @@
module gact_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] y_bits_i,
  input logic        last_out_i
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(y_bits_i) && $stable(last_out_i))
    else $error("stalled result changed");

  // free output slot means input can flow
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i || out_ready_i) |-> in_ready_i)
    else $error("input blocked while output slot free");

  // zero results are always +0
  a_pzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (y_bits_i != 16'h8000))
    else $error("negative zero result");

  // pipeline empty right after reset
  a_rst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result valid after reset");

endmodule

bind gelu_activation_fp16_top gact_checker u_gact_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .y_bits_i    (out_if.y_bits),
  .last_out_i  (out_if.last_out)
);
